// ===== hw/rtl/csc_pkg.sv =====
// Constants and the arctangent table shared by the CORDIC sine/cosine pipeline.
package csc_pkg;

  // Largest arctangent table and the default number of rotation stages
  localparam int ATAN_ENTRIES_MAX = 16;
  localparam int ATAN_ENTRIES_DEF = 16;

  // Iteration count register
  localparam int          ITER_W     = 5;
  localparam logic [4:0]  ITER_RESET = 5'd16;

  // Range reduction: bias that makes any 16-bit angle non-negative, a multiple of 360
  localparam int          RED_W      = 17;
  localparam logic [16:0] DEG_BIAS   = 17'd33120;
  localparam logic [16:0] DEG_TURN   = 17'd360;
  localparam int          RED_STEPS  = 8;
  localparam int          RED_STAGES = 4;

  // Degrees to binary angle: floor(m * 1024 / 45) = (m * RECIP_45) >> RECIP_SHIFT
  localparam int          PROD_W      = 25;
  localparam logic [24:0] RECIP_45    = 25'd372828;
  localparam int          RECIP_SHIFT = 14;

  // Starting x of the rotation (gain-compensated unit vector)
  localparam logic signed [15:0] X_INIT = 16'sh4DBA;

  // Fold marks carried down the pipeline
  typedef struct packed {
    logic oct_pos;
    logic oct_neg;
    logic quad_neg;
  } fold_ctrl_t;

  // Arctangent of 2^-i as a binary angle, 0x4000 = 45 degrees
  function automatic logic [15:0] atan_step(input logic [3:0] idx);
    logic [15:0] val;
    case (idx)
      4'd0:    val = 16'h4000;
      4'd1:    val = 16'h25C8;
      4'd2:    val = 16'h13F6;
      4'd3:    val = 16'h0A22;
      4'd4:    val = 16'h0516;
      4'd5:    val = 16'h028B;
      4'd6:    val = 16'h0145;
      4'd7:    val = 16'h00A2;
      4'd8:    val = 16'h0051;
      4'd9:    val = 16'h0029;
      4'd10:   val = 16'h0014;
      4'd11:   val = 16'h000A;
      4'd12:   val = 16'h0005;
      4'd13:   val = 16'h0003;
      4'd14:   val = 16'h0002;
      default: val = 16'h0001;
    endcase
    return val;
  endfunction

endpackage

// ===== hw/rtl/cordic_sine_cosine.sv =====
// Pipelined CORDIC sine/cosine of an integer angle in degrees, Q15 results.
//
//  channel | ports                           | handshake
//  --------+---------------------------------+----------------------------------
//  request | start, busy, in_angle           | taken when start && !busy
//  result  | out_valid, out_sine, out_cosine | one-cycle strobe, no back-pressure
//  config  | cfg_we, cfg_wdata               | written when cfg_we
//
//  A request enters every cycle; busy stays low. On its way to the result a request
//  passes one input register, four modulo-360 stages, one fold stage, one multiply,
//  one target stage, one rotation stage per table entry and the output register.
//  Reset clears the valid bits and sets the iteration count to 16. The receiver
//  cannot stall, so nothing is held.
module cordic_sine_cosine
  import csc_pkg::*;
#(
  parameter int ANGLE_TABLE_ENTRIES = ATAN_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_angle,
  output logic               out_valid,
  output logic signed [15:0] out_sine,
  output logic signed [15:0] out_cosine,
  input  logic               cfg_we,
  input  logic [ITER_W-1:0]  cfg_wdata
);

  localparam int NS = ANGLE_TABLE_ENTRIES;

  // Configuration register
  logic [ITER_W-1:0] iter_r;
  logic [ITER_W-1:0] iter_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_r <= ITER_RESET;
    end else if (cfg_we) begin
      iter_r <= cfg_wdata;
    end
  end

  // Clip the step count to the table size
  assign iter_eff = (iter_r > ITER_W'(NS)) ? ITER_W'(NS) : iter_r;

  assign busy = 1'b0;

  // Range reduction pipeline: entry register plus four stages of two steps
  logic             red_vld_r [0:RED_STAGES];
  logic [RED_W-1:0] red_u_r   [0:RED_STAGES];
  logic             red_neg_r [0:RED_STAGES];

  // Bias the angle so it is non-negative and keeps its residue mod 360
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_vld_r[0] <= 1'b0;
    end else begin
      red_vld_r[0] <= start;
    end
    red_u_r[0]   <= {in_angle[15], in_angle} + DEG_BIAS;
    red_neg_r[0] <= in_angle[15];
  end

  for (genvar j = 0; j < RED_STAGES; j++) begin : g_red
    localparam int K_HI = RED_STEPS - 1 - 2 * j;
    localparam int K_LO = RED_STEPS - 2 - 2 * j;
    logic [RED_W-1:0] u_a;
    logic [RED_W-1:0] u_b;

    // Subtract 360 * 2^k where it fits, two k per stage
    always_comb begin
      u_a = (red_u_r[j] >= (DEG_TURN << K_HI)) ? red_u_r[j] - (DEG_TURN << K_HI)
                                                : red_u_r[j];
      u_b = (u_a >= (DEG_TURN << K_LO)) ? u_a - (DEG_TURN << K_LO) : u_a;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        red_vld_r[j+1] <= 1'b0;
      end else begin
        red_vld_r[j+1] <= red_vld_r[j];
      end
      red_u_r[j+1]   <= u_b;
      red_neg_r[j+1] <= red_neg_r[j];
    end
  end

  // Fold stage: map to -180..180, then quadrant and octant fold to -45..45
  logic [8:0]        res;
  logic signed [9:0] t_a;
  logic signed [9:0] t_b;
  logic signed [9:0] t_c;
  logic signed [9:0] t_abs;
  fold_ctrl_t        fold_nxt;

  always_comb begin
    res      = red_u_r[RED_STAGES][8:0];
    fold_nxt = '0;
    if (res > 9'd180) begin
      t_a = $signed({1'b0, res}) - 10'sd360;
    end else if (res == 9'd180) begin
      t_a = red_neg_r[RED_STAGES] ? -10'sd180 : 10'sd180;
    end else begin
      t_a = $signed({1'b0, res});
    end
    if (t_a < -10'sd90) begin
      t_b               = t_a + 10'sd180;
      fold_nxt.quad_neg = 1'b1;
    end else if (t_a > 10'sd90) begin
      t_b               = t_a - 10'sd180;
      fold_nxt.quad_neg = 1'b1;
    end else begin
      t_b = t_a;
    end
    if (t_b < -10'sd45) begin
      t_c              = t_b + 10'sd90;
      fold_nxt.oct_neg = 1'b1;
    end else if (t_b > 10'sd45) begin
      t_c              = t_b - 10'sd90;
      fold_nxt.oct_pos = 1'b1;
    end else begin
      t_c = t_b;
    end
    t_abs = t_c[9] ? -t_c : t_c;
  end

  logic       fold_vld_r;
  logic [5:0] fold_mag_r;
  logic       fold_neg_r;
  fold_ctrl_t fold_ctrl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_vld_r <= 1'b0;
    end else begin
      fold_vld_r <= red_vld_r[RED_STAGES];
    end
    fold_mag_r  <= t_abs[5:0];
    fold_neg_r  <= t_c[9];
    fold_ctrl_r <= fold_nxt;
  end

  // Multiply stage: degrees times the reciprocal of 45
  logic              mul_vld_r;
  logic [PROD_W-1:0] mul_prod_r;
  logic              mul_neg_r;
  fold_ctrl_t        mul_ctrl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
    end else begin
      mul_vld_r <= fold_vld_r;
    end
    mul_prod_r <= PROD_W'(fold_mag_r) * RECIP_45;
    mul_neg_r  <= fold_neg_r;
    mul_ctrl_r <= fold_ctrl_r;
  end

  // Rotation pipeline, index 0 is the target stage
  logic               rot_vld_r  [0:NS];
  logic signed [15:0] rot_x_r    [0:NS];
  logic signed [15:0] rot_y_r    [0:NS];
  logic signed [15:0] rot_s_r    [0:NS];
  logic signed [15:0] rot_tgt_r  [0:NS];
  fold_ctrl_t         rot_ctrl_r [0:NS];

  // Target stage: binary angle with the sign of the folded angle
  logic [15:0] tgt_mag;

  assign tgt_mag = {1'b0, mul_prod_r[PROD_W-1:RECIP_SHIFT], 4'b0000};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_vld_r[0] <= 1'b0;
    end else begin
      rot_vld_r[0] <= mul_vld_r;
    end
    rot_x_r[0]    <= X_INIT;
    rot_y_r[0]    <= '0;
    rot_s_r[0]    <= '0;
    rot_tgt_r[0]  <= mul_neg_r ? -$signed(tgt_mag) : $signed(tgt_mag);
    rot_ctrl_r[0] <= mul_ctrl_r;
  end

  for (genvar i = 0; i < NS; i++) begin : g_rot
    logic signed [17:0] diff;
    logic signed [15:0] x_sh;
    logic signed [15:0] y_sh;
    logic [15:0]        atan_val;
    logic signed [15:0] x_nxt;
    logic signed [15:0] y_nxt;
    logic signed [15:0] s_nxt;

    // Rotate toward the target when this step is enabled, else pass through
    always_comb begin
      diff     = 18'(rot_tgt_r[i]) - 18'(rot_s_r[i]);
      x_sh     = rot_x_r[i] >>> i;
      y_sh     = rot_y_r[i] >>> i;
      atan_val = atan_step(4'(i));
      if (ITER_W'(i) >= iter_eff) begin
        x_nxt = rot_x_r[i];
        y_nxt = rot_y_r[i];
        s_nxt = rot_s_r[i];
      end else if (diff > 18'sd0) begin
        x_nxt = rot_x_r[i] - y_sh;
        y_nxt = rot_y_r[i] + x_sh;
        s_nxt = rot_s_r[i] + $signed(atan_val);
      end else begin
        x_nxt = rot_x_r[i] + y_sh;
        y_nxt = rot_y_r[i] - x_sh;
        s_nxt = rot_s_r[i] - $signed(atan_val);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rot_vld_r[i+1] <= 1'b0;
      end else begin
        rot_vld_r[i+1] <= rot_vld_r[i];
      end
      rot_x_r[i+1]    <= x_nxt;
      rot_y_r[i+1]    <= y_nxt;
      rot_s_r[i+1]    <= s_nxt;
      rot_tgt_r[i+1]  <= rot_tgt_r[i];
      rot_ctrl_r[i+1] <= rot_ctrl_r[i];
    end
  end

  // Output fix-up: non-negative cosine, then octant swap and quadrant negate
  logic signed [15:0] fx_x;
  logic signed [15:0] fx_s;
  logic signed [15:0] fx_c;
  logic signed [15:0] sine_nxt;
  logic signed [15:0] cosine_nxt;
  fold_ctrl_t         fx_ctrl;

  always_comb begin
    fx_ctrl = rot_ctrl_r[NS];
    fx_x    = rot_x_r[NS][15] ? -rot_x_r[NS] : rot_x_r[NS];
    if (fx_ctrl.oct_pos) begin
      fx_s = fx_x;
      fx_c = -rot_y_r[NS];
    end else if (fx_ctrl.oct_neg) begin
      fx_s = -fx_x;
      fx_c = rot_y_r[NS];
    end else begin
      fx_s = rot_y_r[NS];
      fx_c = fx_x;
    end
    sine_nxt   = fx_ctrl.quad_neg ? -fx_s : fx_s;
    cosine_nxt = fx_ctrl.quad_neg ? -fx_c : fx_c;
  end

  logic               out_valid_r;
  logic signed [15:0] out_sine_r;
  logic signed [15:0] out_cosine_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= rot_vld_r[NS];
    end
    out_sine_r   <= sine_nxt;
    out_cosine_r <= cosine_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_sine   = out_sine_r;
  assign out_cosine = out_cosine_r;

endmodule
